### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers shared by the irq nesting tracker rtl; empty in synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// checked on clk_i, quiet while rst_ni is low
`define INLT_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// checked on clk_i at every edge, reset included
`define INLT_ASSERT_NR(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define INLT_ASSERT(name, prop, msg)
`define INLT_ASSERT_NR(name, prop, msg)
`endif
`endif

### hw/rtl/inlt_pkg.sv
// ----------------------------------------------------------------------------
// inlt_pkg
// types and constants of the irq nesting and latency tracker
// ----------------------------------------------------------------------------
`default_nettype none

package inlt_pkg;

  // fixed field widths
  localparam int unsigned TIME_W = 48;
  localparam int unsigned RUN_W  = 32;

  // event kind
  typedef enum logic {
    MODE_ENTRY = 1'b0,
    MODE_EXIT  = 1'b1
  } mode_e;

  // result status codes
  typedef enum logic [2:0] {
    STATUS_OK         = 3'd0,
    STATUS_BAD_VECTOR = 3'd1,
    STATUS_TOO_DEEP   = 3'd2,
    STATUS_REENTRY    = 3'd3,
    STATUS_EMPTY_EXIT = 3'd4
  } status_e;

  // trace state of one irq
  typedef enum logic [1:0] {
    TRACE_IDLE      = 2'd0,
    TRACE_RUNNING   = 2'd1,
    TRACE_PREEMPTED = 2'd2
  } trace_e;

  // input transaction
  typedef struct packed {
    mode_e             mode;
    logic [1:0]        cpu;
    logic [7:0]        irq;
    logic [TIME_W-1:0] timestamp;
  } in_item_t;

  // output transaction
  typedef struct packed {
    status_e           status;
    logic              trace_valid;
    logic [1:0]        trace_cpu;
    logic [5:0]        trace_irq;
    trace_e            trace_value;
    logic              last;
    logic              stats_valid;
    logic [RUN_W-1:0]  delta;
    logic [RUN_W-1:0]  max_delta;
    logic [TIME_W-1:0] max_position;
    logic [TIME_W-1:0] busy_sum;
    logic [RUN_W-1:0]  event_count;
  } out_item_t;

  // one entry of the statistics memory
  typedef struct packed {
    logic [TIME_W-1:0] start_stamp;
    logic [RUN_W-1:0]  longest_run;
    logic [TIME_W-1:0] longest_start;
    logic [TIME_W-1:0] busy_total;
    logic [RUN_W-1:0]  run_count;
  } stat_entry_t;

  // statistics after an exit update
  typedef struct packed {
    logic [RUN_W-1:0]  delta;
    logic [RUN_W-1:0]  max_delta;
    logic [TIME_W-1:0] max_position;
    logic [TIME_W-1:0] busy_sum;
    logic [RUN_W-1:0]  event_count;
  } stat_out_t;

  // statistics operation
  typedef enum logic {
    STAT_OP_ENTRY = 1'b0,
    STAT_OP_EXIT  = 1'b1
  } stat_op_e;

  // command from the controller to the statistics unit
  typedef struct packed {
    logic     valid;
    stat_op_e op;
  } stat_cmd_t;

  // status from the statistics unit
  typedef struct packed {
    logic clearing;
    logic done;
  } stat_sts_t;

endpackage

`default_nettype wire

### hw/rtl/inlt_stack_ram.sv
// ----------------------------------------------------------------------------
// inlt_stack_ram
// nesting stack storage: one write port, two registered read ports
// ----------------------------------------------------------------------------
`default_nettype none

module inlt_stack_ram #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned WIDTH = 6,
  localparam int unsigned AddrW = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_a_i,
  input  wire logic [AddrW-1:0] raddr_b_i,
  output logic      [WIDTH-1:0] rdata_a_o,
  output logic      [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] stack_mem [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      stack_mem[waddr_i] <= wdata_i;
    end
  end

  // read ports, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_q <= stack_mem[raddr_a_i];
      rdata_b_q <= stack_mem[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

`default_nettype wire

### hw/rtl/inlt_stats_unit.sv
// ----------------------------------------------------------------------------
// inlt_stats_unit
// per cpu and irq statistics memory with clearing pass and read-modify-write
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module inlt_stats_unit #(
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AddrW = $clog2(DEPTH)
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire inlt_pkg::stat_cmd_t                cmd_i,
  input  wire logic [AddrW-1:0]                   addr_i,
  input  wire logic [inlt_pkg::TIME_W-1:0]        ts_i,
  output inlt_pkg::stat_sts_t                     sts_o,
  output inlt_pkg::stat_out_t                     res_o
);

  typedef enum logic [3:0] {
    SS_CLEAR  = 4'b0001,
    SS_IDLE   = 4'b0010,
    SS_READ   = 4'b0100,
    SS_UPDATE = 4'b1000
  } sstate_e;

  sstate_e                        state_q, state_d;
  logic [AddrW-1:0]               clr_cnt_q, clr_cnt_d;
  inlt_pkg::stat_entry_t          stat_mem [DEPTH];
  inlt_pkg::stat_entry_t          rd_q;
  inlt_pkg::stat_op_e             op_q;
  logic [AddrW-1:0]               addr_q;
  logic [inlt_pkg::TIME_W-1:0]    ts_q;
  logic [inlt_pkg::RUN_W-1:0]     delta_q, delta_d;
  inlt_pkg::stat_out_t            res_q;
  logic [inlt_pkg::TIME_W-1:0]    diff;
  logic [inlt_pkg::TIME_W:0]      sum;
  inlt_pkg::stat_entry_t          upd;
  inlt_pkg::stat_entry_t          ent;
  logic                           mem_re;
  logic                           mem_we;
  logic [AddrW-1:0]               mem_waddr;
  inlt_pkg::stat_entry_t          mem_wdata;

  assign mem_re = cmd_i.valid && (state_q == SS_IDLE);

  // clamped duration of the finished handler
  always_comb begin
    if (ts_q >= rd_q.start_stamp) begin
      diff = ts_q - rd_q.start_stamp;
    end else begin
      diff = '0;
    end
    if (|diff[inlt_pkg::TIME_W-1:inlt_pkg::RUN_W]) begin
      delta_d = '1;
    end else begin
      delta_d = diff[inlt_pkg::RUN_W-1:0];
    end
  end

  // new maximum, saturating total and count
  always_comb begin
    upd = rd_q;
    if (delta_q > rd_q.longest_run) begin
      upd.longest_run   = delta_q;
      upd.longest_start = rd_q.start_stamp;
    end
    sum = {1'b0, rd_q.busy_total} + (inlt_pkg::TIME_W + 1)'(delta_q);
    if (sum[inlt_pkg::TIME_W]) begin
      upd.busy_total = '1;
    end else begin
      upd.busy_total = sum[inlt_pkg::TIME_W-1:0];
    end
    if (rd_q.run_count != '1) begin
      upd.run_count = rd_q.run_count + inlt_pkg::RUN_W'(1);
    end
  end

  // entry only refreshes the entry time
  always_comb begin
    ent             = rd_q;
    ent.start_stamp = ts_q;
  end

  // write port select
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr_q;
    mem_wdata = upd;
    unique case (state_q)
      SS_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_q;
        mem_wdata = '0;
      end
      SS_READ: begin
        mem_we    = (op_q == inlt_pkg::STAT_OP_ENTRY);
        mem_wdata = ent;
      end
      SS_UPDATE: begin
        mem_we = 1'b1;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // statistics memory
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      stat_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= stat_mem[addr_i];
    end
  end

  // sequencer
  always_comb begin
    state_d   = state_q;
    clr_cnt_d = clr_cnt_q;
    unique case (state_q)
      SS_CLEAR: begin
        clr_cnt_d = clr_cnt_q + AddrW'(1);
        if (clr_cnt_q == AddrW'(DEPTH - 1)) begin
          state_d = SS_IDLE;
        end
      end
      SS_IDLE: begin
        if (cmd_i.valid) begin
          state_d = SS_READ;
        end
      end
      SS_READ: begin
        if (op_q == inlt_pkg::STAT_OP_EXIT) begin
          state_d = SS_UPDATE;
        end else begin
          state_d = SS_IDLE;
        end
      end
      SS_UPDATE: begin
        state_d = SS_IDLE;
      end
      default: begin
        state_d = SS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= SS_CLEAR;
      clr_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
    end
  end

  // command capture, duration and result registers
  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      op_q   <= cmd_i.op;
      addr_q <= addr_i;
      ts_q   <= ts_i;
    end
    if (state_q == SS_READ) begin
      delta_q <= delta_d;
    end
    if (state_q == SS_UPDATE) begin
      res_q.delta        <= delta_q;
      res_q.max_delta    <= upd.longest_run;
      res_q.max_position <= upd.longest_start;
      res_q.busy_sum     <= upd.busy_total;
      res_q.event_count  <= upd.run_count;
    end
  end

  assign sts_o.clearing = (state_q == SS_CLEAR);
  assign sts_o.done     = ((state_q == SS_READ) && (op_q == inlt_pkg::STAT_OP_ENTRY)) ||
                          (state_q == SS_UPDATE);
  assign res_o          = res_q;

  // checks
  `INLT_ASSERT_NR(a_cmd_when_idle, cmd_i.valid |-> (state_q == SS_IDLE), "stats command while busy")
  `INLT_ASSERT(a_max_grows, (state_q == SS_UPDATE) |-> (upd.longest_run >= rd_q.longest_run), "maximum shrank")
  `INLT_ASSERT(a_total_grows, (state_q == SS_UPDATE) |-> (upd.busy_total >= rd_q.busy_total), "total shrank")

endmodule

`default_nettype wire

### hw/rtl/irq_nesting_latency_tracker.sv
// ----------------------------------------------------------------------------
// irq_nesting_latency_tracker
// per cpu interrupt nesting tracker with optional handler latency statistics
// ----------------------------------------------------------------------------
// One event is handled at a time. After acceptance an event goes through the
// stack memory read, then, while statistics are enabled, the statistics
// memory update (an entry time write on entry, a read-modify-write on exit),
// then one or two results into the output register, one result per cycle
// while the output is not stalled; a second trace result follows a preempting
// entry or an exit that leaves an irq running. A stalled output holds the
// block longer. After reset the statistics memory is cleared, one entry per
// cycle, for all NUM_CPUS * NUM_IRQS entries, during which no event is taken
// (stats_enable writes still are).
`default_nettype none
`include "assert_macros.svh"

module irq_nesting_latency_tracker #(
  parameter int unsigned NUM_CPUS = 4,
  parameter int unsigned NUM_IRQS = 64
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire inlt_pkg::in_item_t  in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output inlt_pkg::out_item_t      out_data_o,
  input  wire logic                cfg_we_i,
  input  wire logic                cfg_wdata_i
);

  localparam int unsigned Slots = NUM_CPUS * NUM_IRQS;
  localparam int unsigned AddrW = $clog2(Slots);
  localparam int unsigned IrqW  = $clog2(NUM_IRQS);
  localparam int unsigned LvlW  = $clog2(NUM_IRQS + 1);
  localparam int unsigned CpuW  = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_LOOK   = 5'b00010,
    S_STATS  = 5'b00100,
    S_EMIT_A = 5'b01000,
    S_EMIT_B = 5'b10000
  } state_e;

  // cpu number folded into the configured range
  function automatic logic [CpuW-1:0] wrap_cpu(input logic [1:0] c);
    logic [4:0] v;
    v = {3'b000, c};
    for (int i = 0; i < 3; i++) begin
      if (v >= 5'(NUM_CPUS)) begin
        v = v - 5'(NUM_CPUS);
      end
    end
    return CpuW'(v);
  endfunction

  // flat memory address of one cpu and one slot
  function automatic logic [AddrW-1:0] slot_addr(input logic [CpuW-1:0] c,
                                                 input logic [IrqW-1:0] idx);
    return AddrW'(c) * AddrW'(NUM_IRQS) + AddrW'(idx);
  endfunction

  state_e                       state_q, state_d;
  logic                         stats_en_q;
  logic [LvlW-1:0]              level_q [NUM_CPUS];

  // captured event
  inlt_pkg::mode_e              mode_q;
  logic [CpuW-1:0]              cpu_q;
  logic [7:0]                   irq_q;
  logic [inlt_pkg::TIME_W-1:0]  ts_q;
  logic [LvlW-1:0]              lvl_q;
  inlt_pkg::status_e            status_q, status_d;
  logic                         carry_stats_q;

  // output register
  logic                         out_valid_q, out_valid_d;
  inlt_pkg::out_item_t          out_q;
  logic                         out_free;
  logic                         out_load;

  logic                         accept;
  logic [CpuW-1:0]              acc_cpu;
  logic [LvlW-1:0]              acc_lvl;
  logic [IrqW-1:0]              idx_top;
  logic [IrqW-1:0]              idx_below;
  logic [IrqW-1:0]              stk_top;
  logic [IrqW-1:0]              stk_below;
  logic                         is_entry;
  logic                         look_ok;
  logic [LvlW-1:0]              lvl_new;
  logic                         stk_we;
  inlt_pkg::stat_cmd_t          stat_cmd;
  logic [AddrW-1:0]             stat_addr;
  inlt_pkg::stat_sts_t          stat_sts;
  inlt_pkg::stat_out_t          stat_res;
  logic                         has_b;
  inlt_pkg::out_item_t          res_a;
  inlt_pkg::out_item_t          res_b;

  // input handshake and stack read addresses
  assign in_stall_o = (state_q != S_IDLE) || stat_sts.clearing;
  assign accept     = in_valid_i && !in_stall_o;
  assign acc_cpu    = wrap_cpu(in_data_i.cpu);
  assign acc_lvl    = level_q[acc_cpu];
  assign idx_top    = (acc_lvl != '0) ? IrqW'(acc_lvl - LvlW'(1)) : '0;
  assign idx_below  = (acc_lvl > LvlW'(1)) ? IrqW'(acc_lvl - LvlW'(2)) : '0;

  inlt_stack_ram #(
    .DEPTH (Slots),
    .WIDTH (IrqW)
  ) u_stack (
    .clk_i     (clk_i),
    .we_i      (stk_we),
    .waddr_i   (slot_addr(cpu_q, IrqW'(lvl_q))),
    .wdata_i   (IrqW'(irq_q)),
    .re_i      (accept),
    .raddr_a_i (slot_addr(acc_cpu, idx_top)),
    .raddr_b_i (slot_addr(acc_cpu, idx_below)),
    .rdata_a_o (stk_top),
    .rdata_b_o (stk_below)
  );

  // event checks once the stack top is read
  assign is_entry = (mode_q == inlt_pkg::MODE_ENTRY);

  always_comb begin
    if (is_entry) begin
      if ({1'b0, irq_q} >= 9'(NUM_IRQS)) begin
        status_d = inlt_pkg::STATUS_BAD_VECTOR;
      end else if (lvl_q >= LvlW'(NUM_IRQS)) begin
        status_d = inlt_pkg::STATUS_TOO_DEEP;
      end else if ((lvl_q != '0) && (stk_top == IrqW'(irq_q))) begin
        status_d = inlt_pkg::STATUS_REENTRY;
      end else begin
        status_d = inlt_pkg::STATUS_OK;
      end
    end else if (lvl_q == '0) begin
      status_d = inlt_pkg::STATUS_EMPTY_EXIT;
    end else begin
      status_d = inlt_pkg::STATUS_OK;
    end
  end

  assign look_ok = (state_q == S_LOOK) && (status_d == inlt_pkg::STATUS_OK);
  assign lvl_new = is_entry ? (lvl_q + LvlW'(1)) : (lvl_q - LvlW'(1));
  assign stk_we  = look_ok && is_entry;

  // statistics command: entry time capture or exit update
  always_comb begin
    stat_cmd.valid = look_ok && stats_en_q;
    if (is_entry) begin
      stat_cmd.op = inlt_pkg::STAT_OP_ENTRY;
      stat_addr   = slot_addr(cpu_q, IrqW'(irq_q));
    end else begin
      stat_cmd.op = inlt_pkg::STAT_OP_EXIT;
      stat_addr   = slot_addr(cpu_q, stk_top);
    end
  end

  inlt_stats_unit #(
    .DEPTH (Slots)
  ) u_stats (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (stat_cmd),
    .addr_i (stat_addr),
    .ts_i   (ts_q),
    .sts_o  (stat_sts),
    .res_o  (stat_res)
  );

  // first result of the event
  always_comb begin
    res_a        = '0;
    res_a.status = status_q;
    res_a.last   = 1'b1;
    if (status_q == inlt_pkg::STATUS_OK) begin
      res_a.trace_valid = 1'b1;
      res_a.trace_cpu   = 2'(cpu_q);
      if (is_entry) begin
        if (lvl_q != '0) begin
          res_a.trace_irq   = 6'(stk_top);
          res_a.trace_value = inlt_pkg::TRACE_PREEMPTED;
          res_a.last        = 1'b0;
        end else begin
          res_a.trace_irq   = 6'(irq_q);
          res_a.trace_value = inlt_pkg::TRACE_RUNNING;
        end
      end else begin
        res_a.trace_irq   = 6'(stk_top);
        res_a.trace_value = inlt_pkg::TRACE_IDLE;
        res_a.last        = (lvl_q == LvlW'(1));
        if (carry_stats_q) begin
          res_a.stats_valid  = 1'b1;
          res_a.delta        = stat_res.delta;
          res_a.max_delta    = stat_res.max_delta;
          res_a.max_position = stat_res.max_position;
          res_a.busy_sum     = stat_res.busy_sum;
          res_a.event_count  = stat_res.event_count;
        end
      end
    end
  end

  // second result: the irq that now runs
  assign has_b = (status_q == inlt_pkg::STATUS_OK) &&
                 (is_entry ? (lvl_q != '0) : (lvl_q > LvlW'(1)));

  always_comb begin
    res_b             = '0;
    res_b.status      = inlt_pkg::STATUS_OK;
    res_b.trace_valid = 1'b1;
    res_b.trace_cpu   = 2'(cpu_q);
    res_b.trace_irq   = is_entry ? 6'(irq_q) : 6'(stk_below);
    res_b.trace_value = inlt_pkg::TRACE_RUNNING;
    res_b.last        = 1'b1;
  end

  // controller
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_LOOK;
        end
      end
      S_LOOK: begin
        if (look_ok && stats_en_q) begin
          state_d = S_STATS;
        end else begin
          state_d = S_EMIT_A;
        end
      end
      S_STATS: begin
        if (stat_sts.done) begin
          state_d = S_EMIT_A;
        end
      end
      S_EMIT_A: begin
        if (out_free) begin
          state_d = has_b ? S_EMIT_B : S_IDLE;
        end
      end
      S_EMIT_B: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers, nesting levels and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      stats_en_q  <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_CPUS; i++) begin
        level_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        stats_en_q <= cfg_wdata_i;
      end
      if (look_ok) begin
        level_q[cpu_q] <= lvl_new;
      end
    end
  end

  // event capture
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q <= in_data_i.mode;
      cpu_q  <= acc_cpu;
      irq_q  <= in_data_i.irq;
      ts_q   <= in_data_i.timestamp;
      lvl_q  <= acc_lvl;
    end
    if (state_q == S_LOOK) begin
      status_q      <= status_d;
      carry_stats_q <= look_ok && !is_entry && stats_en_q;
    end
  end

  // output register
  assign out_free = !out_valid_q || !out_stall_i;
  assign out_load = ((state_q == S_EMIT_A) || (state_q == S_EMIT_B)) && out_free;

  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= (state_q == S_EMIT_A) ? res_a : res_b;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // checks
  `INLT_ASSERT(a_level_range, (state_q == S_LOOK) |-> (lvl_q <= LvlW'(NUM_IRQS)), "nesting level out of range")
  `INLT_ASSERT(a_second_ok, (state_q == S_EMIT_B) |-> (status_q == inlt_pkg::STATUS_OK), "second result after reject")
  `INLT_ASSERT(a_done_waited, stat_sts.done |-> (state_q == S_STATS), "stats done while not waiting")

endmodule

`default_nettype wire

### tb/irq_nesting_latency_tracker_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// irq_nesting_latency_tracker_tb
// self-checking bench for the per cpu irq nesting and latency tracker
// ----------------------------------------------------------------------------
// Event transactions are queued by the stimulus process and driven by a
// clocked driver with random gaps. A clocked monitor feeds every accepted
// event into a behavioral tracker, which keeps its own nesting stacks and
// statistics and queues the results that the event must produce. Each result
// transaction is compared field by field with the oldest queued result.
// Phases run with statistics on and off; a directed opening covers the
// empty exit, invalid vector and reentry rejections, nesting, backward
// time and saturation of the duration, later phases cover deep nesting,
// long receiver hold-off and back to back long handler runs.
// ----------------------------------------------------------------------------

module irq_nesting_latency_tracker_tb;

  localparam int unsigned CPUS     = 4;
  localparam int unsigned IRQS     = 64;
  localparam int unsigned WD_LIMIT = 2000;
  localparam int unsigned TIME_W   = inlt_pkg::TIME_W;
  localparam int unsigned RUN_W    = inlt_pkg::RUN_W;
  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  // event transaction waiting to be driven
  typedef struct packed {
    inlt_pkg::in_item_t ev;
    logic [2:0]         gap;
    logic               wait_idle;
  } queued_event_t;

  logic                clk_i;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  inlt_pkg::in_item_t  in_data_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  inlt_pkg::out_item_t out_data_o;
  logic                cfg_we_i    = 1'b0;
  logic                cfg_wdata_i = 1'b0;

  // stimulus and expectation stores
  queued_event_t       irq_events[$];
  inlt_pkg::out_item_t due_results[$];

  // behavioral tracker state
  logic              stats_on;
  logic [5:0]        nest_m     [CPUS][IRQS];
  logic [6:0]        depth_m    [CPUS];
  logic [TIME_W-1:0] entered_at [CPUS][IRQS];
  logic [RUN_W-1:0]  longest_m  [CPUS][IRQS];
  logic [TIME_W-1:0] longest_at [CPUS][IRQS];
  logic [TIME_W-1:0] busy_m     [CPUS][IRQS];
  logic [RUN_W-1:0]  runs_m     [CPUS][IRQS];

  // handshake bookkeeping shared between the clocked processes
  logic          in_taken   = 1'b0;
  logic          out_taken  = 1'b0;
  logic          drv_active = 1'b0;
  queued_event_t drv_cur    = '0;
  int unsigned   gap_left   = 0;
  int unsigned   mismatch_count = 0;
  int unsigned   idle_cycles = 0;

  // receiver control
  logic          hold_req = 1'b0;
  logic          rx_rush  = 1'b0;
  logic          rx_calm  = 1'b0;
  int unsigned   rx_hold  = 0;
  int unsigned   rx_wait  = 0;
  int unsigned   rx_seen  = 0;

  // generator control
  logic              burst      = 1'b0;
  logic              pause_next = 1'b0;
  logic [TIME_W-1:0] gen_now    = '0;
  logic [7:0]        last_irq [CPUS];

  irq_nesting_latency_tracker #(
    .NUM_CPUS(CPUS),
    .NUM_IRQS(IRQS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // one trace result with the statistic fields cleared
  function automatic inlt_pkg::out_item_t trace_result(input logic [1:0] c,
                                                       input logic [5:0] v,
                                                       input inlt_pkg::trace_e tv,
                                                       input logic fin);
    inlt_pkg::out_item_t r;
    r = '0;
    r.status      = inlt_pkg::STATUS_OK;
    r.trace_valid = 1'b1;
    r.trace_cpu   = c;
    r.trace_irq   = v;
    r.trace_value = tv;
    r.last        = fin;
    return r;
  endfunction

  // updates the tracker with one accepted event and queues its results
  task automatic apply_irq_event(input inlt_pkg::in_item_t ev);
    inlt_pkg::out_item_t r;
    logic [1:0]          c;
    logic [6:0]          lvl;
    logic [5:0]          top;
    logic [TIME_W-1:0]   d;
    c   = ev.cpu;
    lvl = depth_m[c];
    r   = '0;
    r.last = 1'b1;
    if (ev.mode == inlt_pkg::MODE_ENTRY) begin
      // rejection checks in priority order
      if (ev.irq >= IRQS) begin
        r.status = inlt_pkg::STATUS_BAD_VECTOR;
        due_results.push_back(r);
      end else if (lvl == IRQS) begin
        r.status = inlt_pkg::STATUS_TOO_DEEP;
        due_results.push_back(r);
      end else if (lvl != 0 && nest_m[c][lvl-1] == ev.irq[5:0]) begin
        r.status = inlt_pkg::STATUS_REENTRY;
        due_results.push_back(r);
      end else begin
        if (lvl != 0)
          due_results.push_back(trace_result(c, nest_m[c][lvl-1],
                                             inlt_pkg::TRACE_PREEMPTED, 1'b0));
        due_results.push_back(trace_result(c, ev.irq[5:0], inlt_pkg::TRACE_RUNNING, 1'b1));
        nest_m[c][lvl] = ev.irq[5:0];
        depth_m[c]     = lvl + 7'd1;
        if (stats_on)
          entered_at[c][ev.irq[5:0]] = ev.timestamp;
      end
    end else begin
      if (lvl == 0) begin
        r.status = inlt_pkg::STATUS_EMPTY_EXIT;
        due_results.push_back(r);
      end else begin
        lvl        = lvl - 7'd1;
        depth_m[c] = lvl;
        top        = nest_m[c][lvl];
        r = trace_result(c, top, inlt_pkg::TRACE_IDLE, lvl == 0);
        if (stats_on) begin
          // duration clamps at zero when time runs backwards, saturates at 32 bits
          d = (ev.timestamp >= entered_at[c][top]) ? ev.timestamp - entered_at[c][top] : '0;
          if (d > TIME_W'(32'hFFFF_FFFF))
            d = TIME_W'(32'hFFFF_FFFF);
          if (d > TIME_W'(longest_m[c][top])) begin
            longest_m[c][top]  = d[RUN_W-1:0];
            longest_at[c][top] = entered_at[c][top];
          end
          if (d > TIME_MAX - busy_m[c][top])
            busy_m[c][top] = TIME_MAX;
          else
            busy_m[c][top] = busy_m[c][top] + d;
          if (runs_m[c][top] != '1)
            runs_m[c][top] = runs_m[c][top] + 1'b1;
          r.stats_valid  = 1'b1;
          r.delta        = d[RUN_W-1:0];
          r.max_delta    = longest_m[c][top];
          r.max_position = longest_at[c][top];
          r.busy_sum     = busy_m[c][top];
          r.event_count  = runs_m[c][top];
        end
        due_results.push_back(r);
        if (lvl != 0)
          due_results.push_back(trace_result(c, nest_m[c][lvl-1],
                                             inlt_pkg::TRACE_RUNNING, 1'b1));
      end
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      mismatch_count++;
      $display("%0t %s mismatch: expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  // driver: presents queued events, random gap after each accepted one
  always @(negedge clk_i) begin : driver
    if (rst_ni) begin
      if (drv_active && in_taken) begin
        drv_active = 1'b0;
        gap_left   = drv_cur.gap;
      end
      if (!drv_active) begin
        if (gap_left != 0)
          gap_left--;
        else if (irq_events.size() != 0 &&
                 (!irq_events[0].wait_idle || due_results.size() == 0)) begin
          drv_cur    = irq_events.pop_front();
          drv_active = 1'b1;
        end
      end
    end
    in_valid_i <= drv_active;
    in_data_i  <= drv_cur.ev;
  end

  // receiver: random stall per result, calm stretches, one long hold-off
  always @(negedge clk_i) begin : receiver
    if (out_taken) begin
      rx_seen++;
      if (rx_seen % 40 == 0)
        rx_calm = ($urandom_range(0, 3) == 0);
      rx_wait = (rx_calm || rx_rush) ? 0 : $urandom_range(0, 7);
    end
    if (hold_req) begin
      hold_req = 1'b0;
      rx_hold  = 150;
    end
    if (rx_hold != 0 && !rx_rush) begin
      rx_hold--;
      out_stall_i <= 1'b1;
    end else if (rx_wait != 0) begin
      rx_wait--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // monitor: checks results, feeds accepted events to the tracker, watchdog
  always @(posedge clk_i) begin : monitor
    inlt_pkg::out_item_t want;
    in_taken  = rst_ni && in_valid_i && !in_stall_o;
    out_taken = rst_ni && out_valid_o && !out_stall_i;
    if (out_taken) begin
      if (due_results.size() == 0) begin
        mismatch_count++;
        $display("%0t unexpected result: expected none actual %h", $time, out_data_o);
      end else begin
        want = due_results.pop_front();
        check_field("status",       want.status,       out_data_o.status);
        check_field("trace_valid",  want.trace_valid,  out_data_o.trace_valid);
        check_field("trace_cpu",    want.trace_cpu,    out_data_o.trace_cpu);
        check_field("trace_irq",    want.trace_irq,    out_data_o.trace_irq);
        check_field("trace_value",  want.trace_value,  out_data_o.trace_value);
        check_field("last",         want.last,         out_data_o.last);
        check_field("stats_valid",  want.stats_valid,  out_data_o.stats_valid);
        check_field("delta",        want.delta,        out_data_o.delta);
        check_field("max_delta",    want.max_delta,    out_data_o.max_delta);
        check_field("max_position", want.max_position, out_data_o.max_position);
        check_field("busy_sum",     want.busy_sum,     out_data_o.busy_sum);
        check_field("event_count",  want.event_count,  out_data_o.event_count);
      end
    end
    if (in_taken)
      apply_irq_event(in_data_i);
    if (in_taken || out_taken)
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WD_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic push_event(input inlt_pkg::mode_e m, input logic [1:0] c,
                            input logic [7:0] v, input logic [TIME_W-1:0] ts);
    queued_event_t q;
    q.ev.mode      = m;
    q.ev.cpu       = c;
    q.ev.irq       = v;
    q.ev.timestamp = ts;
    q.gap          = burst ? 3'd0 : 3'($urandom_range(0, 7));
    q.wait_idle    = pause_next;
    pause_next     = 1'b0;
    irq_events.push_back(q);
  endtask

  // mostly well-formed entry and exit traffic, some rejected events
  task automatic random_events(input int unsigned n);
    logic [1:0]        c;
    logic [63:0]       r64;
    logic [TIME_W-1:0] ts;
    int unsigned       pick;
    repeat (n) begin
      c       = 2'($urandom_range(0, 3));
      gen_now = gen_now + TIME_W'($urandom_range(1, 3000));
      r64     = {$urandom, $urandom};
      ts      = ($urandom_range(0, 19) == 0) ? r64[TIME_W-1:0] : gen_now;
      pick    = $urandom_range(0, 99);
      if (pick < 48) begin
        last_irq[c] = 8'($urandom_range(0, IRQS - 1));
        push_event(inlt_pkg::MODE_ENTRY, c, last_irq[c], ts);
      end else if (pick < 90) begin
        push_event(inlt_pkg::MODE_EXIT, c, 8'($urandom), ts);
      end else if (pick < 95) begin
        push_event(inlt_pkg::MODE_ENTRY, c, 8'($urandom_range(IRQS, 255)), ts);
      end else begin
        push_event(inlt_pkg::MODE_ENTRY, c, last_irq[c], ts);
      end
      if ($urandom_range(0, 31) == 0)
        burst = !burst;
    end
  endtask

  task automatic wait_drained();
    while (irq_events.size() != 0 || drv_active || due_results.size() != 0)
      @(posedge clk_i);
  endtask

  // stats_enable write, only once the block has gone idle
  task automatic set_stats(input logic enable);
    wait_drained();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= enable;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    stats_on  = enable;
    @(posedge clk_i);
  endtask

  // stimulus sequence
  initial begin : stimulus
    logic [63:0] r64;
    stats_on = 1'b0;
    foreach (depth_m[c]) begin
      depth_m[c]  = '0;
      last_irq[c] = '0;
    end
    foreach (nest_m[c, i]) begin
      nest_m[c][i]     = '0;
      entered_at[c][i] = '0;
      longest_m[c][i]  = '0;
      longest_at[c][i] = '0;
      busy_m[c][i]     = '0;
      runs_m[c][i]     = '0;
    end
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed opening with statistics on
    set_stats(1'b1);
    push_event(inlt_pkg::MODE_EXIT,  2'd0, 8'd0,   48'd0);      // exit on empty stack
    push_event(inlt_pkg::MODE_ENTRY, 2'd0, 8'd255, 48'd10);     // invalid vectors
    push_event(inlt_pkg::MODE_ENTRY, 2'd0, 8'd64,  48'd20);
    push_event(inlt_pkg::MODE_ENTRY, 2'd0, 8'd0,   48'd100);
    push_event(inlt_pkg::MODE_ENTRY, 2'd0, 8'd0,   48'd110);    // same irq again
    push_event(inlt_pkg::MODE_ENTRY, 2'd0, 8'd63,  48'd120);    // preempts irq 0
    push_event(inlt_pkg::MODE_EXIT,  2'd0, 8'hAA,  48'd150);    // irq field ignored
    push_event(inlt_pkg::MODE_EXIT,  2'd0, 8'd0,   48'd50);     // time went backwards
    push_event(inlt_pkg::MODE_ENTRY, 2'd3, 8'd42,  48'd0);
    push_event(inlt_pkg::MODE_EXIT,  2'd3, 8'd0,   TIME_MAX);   // duration saturates
    push_event(inlt_pkg::MODE_ENTRY, 2'd3, 8'd42,  TIME_MAX);
    push_event(inlt_pkg::MODE_EXIT,  2'd3, 8'd0,   TIME_MAX);
    push_event(inlt_pkg::MODE_ENTRY, 2'd1, 8'd21,  48'd1000);
    push_event(inlt_pkg::MODE_ENTRY, 2'd2, 8'd21,  48'd2000);
    push_event(inlt_pkg::MODE_ENTRY, 2'd1, 8'd42,  48'd1500);
    push_event(inlt_pkg::MODE_EXIT,  2'd2, 8'd0,   48'd2600);
    push_event(inlt_pkg::MODE_EXIT,  2'd1, 8'd0,   48'd1700);
    push_event(inlt_pkg::MODE_EXIT,  2'd1, 8'd0,   48'd1900);
    push_event(inlt_pkg::MODE_ENTRY, 2'd1, 8'd21,  48'd3000);
    push_event(inlt_pkg::MODE_EXIT,  2'd1, 8'd0,   48'd3010);
    push_event(inlt_pkg::MODE_EXIT,  2'd1, 8'd0,   48'd3020);

    // statistics off, leave one open handler per cpu for the next phase
    set_stats(1'b0);
    r64     = {$urandom, $urandom};
    gen_now = r64[TIME_W-1:0] >> 2;
    random_events(50);
    for (int c = 0; c < CPUS; c++)
      push_event(inlt_pkg::MODE_ENTRY, 2'(c), 8'($urandom_range(0, IRQS - 1)), gen_now);

    // statistics on, long receiver hold-off and one sender pause
    set_stats(1'b1);
    random_events(50);
    hold_req   = 1'b1;
    pause_next = 1'b1;
    random_events(50);

    // deep nesting on cpu 2 up to and past the limit
    burst = 1'b0;
    for (int k = 0; k < 70; k++)
      push_event(inlt_pkg::MODE_ENTRY, 2'd2, 8'(k % IRQS), gen_now + TIME_W'(k));
    push_event(inlt_pkg::MODE_ENTRY, 2'd2, 8'd200, gen_now);    // invalid vector wins
    for (int k = 0; k < 72; k++)
      push_event(inlt_pkg::MODE_EXIT, 2'd2, 8'($urandom), gen_now + TIME_W'(100 + k));

    set_stats(1'b0);
    random_events(30);

    // back to back long handler runs on cpu 3, irq 62
    set_stats(1'b1);
    rx_rush = 1'b1;
    burst   = 1'b1;
    for (int k = 0; k < 20; k++) begin
      push_event(inlt_pkg::MODE_ENTRY, 2'd3, 8'd62, 48'd0);
      push_event(inlt_pkg::MODE_EXIT,  2'd3, 8'd0,  48'h100_0000_0000);
    end
    wait_drained();
    rx_rush = 1'b0;
    burst   = 1'b0;

    set_stats(1'b0);
    random_events(30);

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
